// File: rtl/core/i2cms_pkg.sv
// Shared types, codes and constants of the I2C master bit sequencer.
package i2cms_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [3:0] BITS_PER_BYTE = 4'(BitsPerByte);

  // Command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;
  localparam logic [2:0] CMD_NACK  = 3'd6;

  // Sequence phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ST_A      = 4'd1;
  localparam logic [3:0] PH_ST_B      = 4'd2;
  localparam logic [3:0] PH_SP_A      = 4'd3;
  localparam logic [3:0] PH_SP_B      = 4'd4;
  localparam logic [3:0] PH_WR_LOW    = 4'd5;
  localparam logic [3:0] PH_WR_HIGH   = 4'd6;
  localparam logic [3:0] PH_RD_LOW    = 4'd7;
  localparam logic [3:0] PH_RD_SAMPLE = 4'd8;
  localparam logic [3:0] PH_RD_HIGH   = 4'd9;
  localparam logic [3:0] PH_RD_GAP    = 4'd10;
  localparam logic [3:0] PH_AK_A      = 4'd11;
  localparam logic [3:0] PH_AK_B      = 4'd12;
  localparam logic [3:0] PH_WA_POLL   = 4'd13;
  localparam logic [3:0] PH_WA_LAST   = 4'd14;

  // Configuration register indexes
  localparam logic CFG_DELAY_TICKS = 1'b0;
  localparam logic CFG_ACK_LIMIT   = 1'b1;

  localparam logic [15:0] DELAY_TICKS_RST = 16'd1;
  localparam logic [7:0]  ACK_LIMIT_RST   = 8'd250;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  active_cmd;
    logic [3:0]  phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [15:0] delay;
    logic [7:0]  timeout;
    logic        scl;
    logic        sda;
    logic        ack_choice;
    logic        fail;
    logic [7:0]  rx_hold;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    active_cmd: 3'd0, phase: PH_IDLE, bit_cnt: 4'd0, shift: 8'd0, delay: 16'd0,
    timeout: 8'd0, scl: 1'b1, sda: 1'b1, ack_choice: 1'b0, fail: 1'b0,
    rx_hold: 8'd0
  };

endpackage

// File: rtl/core/i2cms_if.sv
// Valid/ready channel interfaces for tick items and line results.
interface i2cms_in_if;
  logic                valid;
  logic                ready;
  i2cms_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cms_out_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/i2c_master_bit_sequencer.sv
// Top level: I2C master bit sequencer, one tick item in, one line result out.
// A result is registered and becomes valid in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle while the result side takes results; the state register and the result
// register are updated together, and the result register frees itself as it drains.
// Reset: rst_ni (async, active low) idles the sequencer with both lines released
// high, empties the result register and loads delay 1 and ack limit 250.
module i2c_master_bit_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  i2cms_in_if.sink           in_i,
  i2cms_out_if.source        out_o
);
  import i2cms_pkg::*;

  logic [15:0] delay_ticks_q;
  logic [7:0]  ack_limit_q;
  seq_state_t  st_q;
  seq_state_t  st_d;
  out_item_t   res_d;
  out_item_t   res_q;
  logic        out_valid_q;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= DELAY_TICKS_RST;
      ack_limit_q   <= ACK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_TICKS: delay_ticks_q <= cfg_wdata_i;
        CFG_ACK_LIMIT:   ack_limit_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  i2cms_step u_step (
    .st_i          (st_q),
    .item_i        (in_i.data),
    .delay_ticks_i (delay_ticks_q),
    .ack_limit_i   (ack_limit_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  // Take a new tick whenever the result register is empty or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SEQ_STATE_RST;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      st_q        <= st_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule

// File: rtl/core/i2cms_step.sv
// Next-state and line result logic for one tick of the sequencer.
module i2cms_step (
  input  i2cms_pkg::seq_state_t st_i,
  input  i2cms_pkg::in_item_t   item_i,
  input  logic [15:0]           delay_ticks_i,
  input  logic [7:0]            ack_limit_i,
  output i2cms_pkg::seq_state_t st_o,
  output i2cms_pkg::out_item_t  res_o
);
  import i2cms_pkg::*;

  seq_state_t nx;
  logic        done;
  logic [3:0]  ph;
  logic [15:0] load_val;
  logic [7:0]  shifted;
  logic [3:0]  bit_next;

  // Zero delay counts as one tick
  assign load_val = (delay_ticks_i == '0) ? 16'd1 : delay_ticks_i;

  always_comb begin
    nx       = st_i;
    done     = 1'b0;
    ph       = st_i.phase;
    shifted  = {st_i.shift[6:0], 1'b0};
    bit_next = st_i.bit_cnt + 4'd1;
    if (st_i.phase == PH_IDLE) begin
      if (item_i.command_valid) begin
        nx.active_cmd = item_i.command;
        nx.bit_cnt    = '0;
        nx.delay      = load_val;
        case (item_i.command)
          CMD_START: begin
            nx.scl = 1'b1; nx.sda = 1'b1; nx.phase = PH_ST_A;
          end
          CMD_STOP: begin
            nx.scl = 1'b0; nx.sda = 1'b0; nx.phase = PH_SP_A;
          end
          CMD_WRITE: begin
            nx.shift = item_i.tx_byte;
            nx.scl   = 1'b0;
            nx.sda   = item_i.tx_byte[7];
            nx.phase = PH_WR_LOW;
          end
          CMD_READ: begin
            nx.shift      = '0;
            nx.ack_choice = item_i.ack_after_read;
            nx.sda        = 1'b1;
            nx.scl        = 1'b0;
            nx.phase      = PH_RD_LOW;
          end
          CMD_WAIT: begin
            nx.timeout = '0;
            nx.sda     = 1'b1;
            nx.scl     = 1'b1;
            nx.phase   = PH_WA_POLL;
          end
          CMD_ACK: begin
            nx.sda = 1'b0; nx.phase = PH_AK_A;
          end
          CMD_NACK: begin
            nx.sda = 1'b1; nx.phase = PH_AK_A;
          end
          default: begin
            // unused code: drop it, stay idle
            nx.active_cmd = CMD_START;
            nx.delay      = st_i.delay;
          end
        endcase
      end
    end else begin
      // sample the read bit on the first tick after SCL rises
      if (st_i.phase == PH_RD_SAMPLE) begin
        nx.shift = {st_i.shift[6:0], item_i.sda_sample};
        nx.phase = PH_RD_HIGH;
        ph       = PH_RD_HIGH;
      end
      if (st_i.delay > 16'd1) begin
        nx.delay = st_i.delay - 16'd1;
      end else begin
        nx.delay = load_val;
        case (ph)
          PH_ST_A: begin
            nx.sda = 1'b0; nx.phase = PH_ST_B;
          end
          PH_ST_B: begin
            nx.scl = 1'b0; nx.phase = PH_IDLE; done = 1'b1;
          end
          PH_SP_A: begin
            nx.scl = 1'b1; nx.phase = PH_SP_B;
          end
          PH_SP_B: begin
            nx.sda = 1'b1;
            // stop issued after an ack timeout: park SCL low and flag it
            if (st_i.active_cmd == CMD_WAIT) begin
              nx.scl  = 1'b0;
              nx.fail = 1'b1;
            end
            nx.phase = PH_IDLE;
            done     = 1'b1;
          end
          PH_WR_LOW: begin
            nx.scl = 1'b1; nx.phase = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            nx.shift   = shifted;
            nx.scl     = 1'b0;
            nx.bit_cnt = bit_next;
            if (bit_next >= BITS_PER_BYTE) begin
              nx.phase = PH_IDLE;
              done     = 1'b1;
            end else begin
              nx.sda   = shifted[7];
              nx.phase = PH_WR_LOW;
            end
          end
          PH_RD_LOW: begin
            nx.scl = 1'b1; nx.phase = PH_RD_SAMPLE;
          end
          PH_RD_HIGH: begin
            nx.scl     = 1'b0;
            nx.bit_cnt = bit_next;
            if (bit_next >= BITS_PER_BYTE) begin
              nx.rx_hold = nx.shift;
              nx.phase   = PH_RD_GAP;
            end else begin
              nx.phase = PH_RD_LOW;
            end
          end
          PH_RD_GAP: begin
            nx.sda   = ~st_i.ack_choice;
            nx.phase = PH_AK_A;
          end
          PH_AK_A: begin
            nx.scl = 1'b1; nx.phase = PH_AK_B;
          end
          PH_AK_B: begin
            nx.scl = 1'b0; nx.phase = PH_IDLE; done = 1'b1;
          end
          PH_WA_POLL: begin
            if (!item_i.sda_sample) begin
              nx.scl   = 1'b0;
              nx.fail  = 1'b0;
              nx.phase = PH_IDLE;
              done     = 1'b1;
            end else if (st_i.timeout >= ack_limit_i) begin
              nx.phase = PH_WA_LAST;
            end else begin
              nx.timeout = st_i.timeout + 8'd1;
              nx.phase   = PH_WA_POLL;
            end
          end
          PH_WA_LAST: begin
            nx.scl   = 1'b0;
            nx.sda   = 1'b0;
            nx.phase = PH_SP_A;
          end
          default: begin
            nx.phase = PH_IDLE; done = 1'b1;
          end
        endcase
        if (done) begin
          nx.delay = '0;
        end
      end
    end
  end

  assign st_o = nx;

  always_comb begin
    res_o.scl_level  = nx.scl;
    res_o.sda_level  = nx.sda;
    res_o.busy_res   = (nx.phase != PH_IDLE);
    res_o.done_res   = done;
    res_o.rx_byte    = nx.rx_hold;
    res_o.ack_failed = nx.fail;
  end

endmodule

// File: rtl/core/i2cms_checker.sv
// Port-level assertions for the I2C master bit sequencer, bound to the top level.
module i2cms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input i2cms_pkg::out_item_t out_data_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Every accepted tick yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted tick produced no result");

  // No new tick while a result waits and the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("tick accepted over a stalled result");

  // Completion tick is never a busy tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.done_res |-> !out_data_i.busy_res)
    else $error("done reported while busy");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: verif/i2c_master_bit_sequencer_tb.sv
// Self-checking testbench for the I2C master bit sequencer: directed and random tick streams.
module i2c_master_bit_sequencer_tb;
  import i2cms_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int ActiveGoal = 600;

  typedef enum int {SDA_RANDOM, SDA_HIGH, SDA_ACK_AT} sda_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_bit_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predicted line state and configuration
  seq_state_t  line_st       = SEQ_STATE_RST;
  logic        line_done     = 1'b0;
  logic [15:0] m_delay_ticks = DELAY_TICKS_RST;
  logic [7:0]  m_ack_limit   = ACK_LIMIT_RST;

  out_item_t line_expected[$];

  int ticks_sent   = 0;
  int active_ticks = 0;
  int cmds_started = 0;
  int cfg_writes   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int ready_pct    = 100;
  int hold_req     = 0;
  int hold_len     = 0;

  function automatic void enter_phase(logic [3:0] ph);
    line_st.phase = ph;
    line_st.delay = (m_delay_ticks != 16'd0) ? m_delay_ticks : 16'd1;
  endfunction

  function automatic void close_sequence();
    line_st.phase = PH_IDLE;
    line_st.delay = 16'd0;
    line_done = 1'b1;
  endfunction

  function automatic out_item_t line_step(in_item_t it);
    out_item_t r;
    line_done = 1'b0;
    if (line_st.phase == PH_IDLE) begin
      if (it.command_valid) begin
        line_st.active_cmd = it.command;
        line_st.bit_cnt = 4'd0;
        case (it.command)
          CMD_START: begin
            line_st.scl = 1'b1;
            line_st.sda = 1'b1;
            enter_phase(PH_ST_A);
          end
          CMD_STOP: begin
            line_st.scl = 1'b0;
            line_st.sda = 1'b0;
            enter_phase(PH_SP_A);
          end
          CMD_WRITE: begin
            line_st.shift = it.tx_byte;
            line_st.scl = 1'b0;
            line_st.sda = it.tx_byte[7];
            enter_phase(PH_WR_LOW);
          end
          CMD_READ: begin
            line_st.shift = 8'd0;
            line_st.ack_choice = it.ack_after_read;
            line_st.sda = 1'b1;
            line_st.scl = 1'b0;
            enter_phase(PH_RD_LOW);
          end
          CMD_WAIT: begin
            line_st.timeout = 8'd0;
            line_st.sda = 1'b1;
            line_st.scl = 1'b1;
            enter_phase(PH_WA_POLL);
          end
          CMD_ACK: begin
            line_st.sda = 1'b0;
            enter_phase(PH_AK_A);
          end
          CMD_NACK: begin
            line_st.sda = 1'b1;
            enter_phase(PH_AK_A);
          end
          default: line_st.active_cmd = 3'd0;
        endcase
      end
    end else begin
      // A read samples SDA on the first tick after SCL rises
      if (line_st.phase == PH_RD_SAMPLE) begin
        line_st.shift = {line_st.shift[6:0], it.sda_sample};
        line_st.phase = PH_RD_HIGH;
      end
      if (line_st.delay > 16'd1) begin
        line_st.delay = line_st.delay - 16'd1;
      end else begin
        line_st.delay = 16'd0;
        case (line_st.phase)
          PH_ST_A: begin
            line_st.sda = 1'b0;
            enter_phase(PH_ST_B);
          end
          PH_ST_B: begin
            line_st.scl = 1'b0;
            close_sequence();
          end
          PH_SP_A: begin
            line_st.scl = 1'b1;
            enter_phase(PH_SP_B);
          end
          PH_SP_B: begin
            line_st.sda = 1'b1;
            // Stop issued by a timed-out wait: drop SCL and flag the failure
            if (line_st.active_cmd == CMD_WAIT) begin
              line_st.scl = 1'b0;
              line_st.fail = 1'b1;
            end
            close_sequence();
          end
          PH_WR_LOW: begin
            line_st.scl = 1'b1;
            enter_phase(PH_WR_HIGH);
          end
          PH_WR_HIGH: begin
            line_st.shift = line_st.shift << 1;
            line_st.scl = 1'b0;
            line_st.bit_cnt = line_st.bit_cnt + 4'd1;
            if (line_st.bit_cnt >= BITS_PER_BYTE) begin
              close_sequence();
            end else begin
              line_st.sda = line_st.shift[7];
              enter_phase(PH_WR_LOW);
            end
          end
          PH_RD_LOW: begin
            line_st.scl = 1'b1;
            enter_phase(PH_RD_SAMPLE);
          end
          PH_RD_HIGH: begin
            line_st.scl = 1'b0;
            line_st.bit_cnt = line_st.bit_cnt + 4'd1;
            if (line_st.bit_cnt >= BITS_PER_BYTE) begin
              line_st.rx_hold = line_st.shift;
              enter_phase(PH_RD_GAP);
            end else begin
              enter_phase(PH_RD_LOW);
            end
          end
          PH_RD_GAP: begin
            line_st.sda = ~line_st.ack_choice;
            enter_phase(PH_AK_A);
          end
          PH_AK_A: begin
            line_st.scl = 1'b1;
            enter_phase(PH_AK_B);
          end
          PH_AK_B: begin
            line_st.scl = 1'b0;
            close_sequence();
          end
          PH_WA_POLL: begin
            if (!it.sda_sample) begin
              line_st.scl = 1'b0;
              line_st.fail = 1'b0;
              close_sequence();
            end else if (line_st.timeout >= m_ack_limit) begin
              enter_phase(PH_WA_LAST);
            end else begin
              line_st.timeout = line_st.timeout + 8'd1;
              enter_phase(PH_WA_POLL);
            end
          end
          PH_WA_LAST: begin
            line_st.scl = 1'b0;
            line_st.sda = 1'b0;
            enter_phase(PH_SP_A);
          end
          default: close_sequence();
        endcase
      end
    end
    r.scl_level  = line_st.scl;
    r.sda_level  = line_st.sda;
    r.busy_res   = (line_st.phase != PH_IDLE);
    r.done_res   = line_done;
    r.rx_byte    = line_st.rx_hold;
    r.ack_failed = line_st.fail;
    return r;
  endfunction

  function automatic string show_line(out_item_t r);
    return $sformatf("scl=%b sda=%b busy=%b done=%b rx=%h fail=%b", r.scl_level, r.sda_level,
                     r.busy_res, r.done_res, r.rx_byte, r.ack_failed);
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Drive one tick in bursts with random gaps; predict its result on acceptance
  task automatic send_tick(in_item_t it);
    out_item_t r;
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    if (line_st.phase == PH_IDLE && it.command_valid && it.command != CMD_UNUSED)
      cmds_started++;
    r = line_step(it);
    line_expected.push_back(r);
    ticks_sent++;
    if (r.busy_res || r.done_res) active_ticks++;
  endtask

  // Hold the input, drain every pending transaction, then write one register
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (line_expected.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DELAY_TICKS) m_delay_ticks = val;
    else m_ack_limit = val[7:0];
    cfg_writes++;
  endtask

  // One tick while a sequence runs: random junk commands, SDA per mode
  task automatic tick_busy(sda_mode_e mode, int sda_at, int n_tick);
    in_item_t it;
    it.command_valid  = ($urandom_range(0, 3) == 0);
    it.command        = 3'($urandom_range(0, 7));
    it.tx_byte        = 8'($urandom);
    it.ack_after_read = 1'($urandom);
    case (mode)
      SDA_HIGH:   it.sda_sample = 1'b1;
      SDA_ACK_AT: it.sda_sample = (n_tick < sda_at);
      default:    it.sda_sample = 1'($urandom);
    endcase
    send_tick(it);
  endtask

  // Start a command from idle and run it until done (or for max_ticks ticks)
  task automatic issue_cmd(logic [2:0] cmd, logic [7:0] tx, logic ack, sda_mode_e mode,
                           int sda_at, int max_ticks);
    in_item_t it;
    int n;
    it = '{command_valid: 1'b1, command: cmd, tx_byte: tx, ack_after_read: ack,
           sda_sample: 1'($urandom)};
    send_tick(it);
    n = 1;
    while (line_st.phase != PH_IDLE && (max_ticks == 0 || n < max_ticks)) begin
      tick_busy(mode, sda_at, n);
      n++;
    end
  endtask

  task automatic test_reset_defaults();
    in_item_t it;
    repeat (3) begin
      it = '{command_valid: 1'b0, command: 3'($urandom), tx_byte: 8'($urandom),
             ack_after_read: 1'($urandom), sda_sample: 1'($urandom)};
      send_tick(it);
    end
    issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    // Default ack limit: SDA never drops, so the wait times out and stops the bus
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 0, 0);
  endtask

  task automatic test_each_command();
    write_reg(CFG_DELAY_TICKS, 16'd2);
    write_reg(CFG_ACK_LIMIT, 16'h0003);
    issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_WRITE, 8'h81, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_ACK_AT, 3, 0);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 0, 0);
    issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0, 0);
    issue_cmd(CMD_READ, 8'hFF, 1'b0, SDA_ACK_AT, 0, 0);
    issue_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_ACK, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_NACK, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_UNUSED, 8'hA5, 1'b1, SDA_RANDOM, 0, 0);
  endtask

  task automatic test_ack_limits();
    write_reg(CFG_DELAY_TICKS, 16'd1);
    write_reg(CFG_ACK_LIMIT, 16'h0000);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 0, 0);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_ACK_AT, 0, 0);
    write_reg(CFG_ACK_LIMIT, 16'hA5FF);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 0, 0);
    issue_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_ACK_AT, 120, 0);
  endtask

  task automatic test_delay_extremes();
    // Zero delay behaves as one tick
    write_reg(CFG_DELAY_TICKS, 16'd0);
    issue_cmd(CMD_NACK, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    write_reg(CFG_DELAY_TICKS, 16'd40);
    ready_pct = 100;
    gaps_on = 1'b0;
    issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 16);
    // Rewrite mid-delay: the running delay keeps counting, the next one uses the new value
    write_reg(CFG_DELAY_TICKS, 16'd3);
    while (line_st.phase != PH_IDLE) tick_busy(SDA_RANDOM, 0, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_DELAY_TICKS, 16'd3);
    ready_pct = 100;
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_req = 400;
    hold_len = 400;
    issue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    issue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    in_item_t it;
    int goal, kind, n, d, lim;
    logic [7:0] addr;
    goal = active_ticks + ActiveGoal;
    while (active_ticks < goal) begin
      if ($urandom_range(0, 24) == 0 || active_ticks + ActiveGoal == goal) begin
        write_reg(CFG_DELAY_TICKS,
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
        write_reg(CFG_ACK_LIMIT, {8'($urandom), 8'($urandom_range(0, 6))});
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 85;
          2:       ready_pct = 55;
          default: ready_pct = 25;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      d = (m_delay_ticks == 16'd0) ? 1 : int'(m_delay_ticks);
      lim = int'(m_ack_limit);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        addr = 8'($urandom);
        issue_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 0, 0);
        issue_cmd(CMD_WRITE, addr, 1'($urandom), SDA_RANDOM, 0, 0);
        issue_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), SDA_ACK_AT,
                  $urandom_range(0, (lim + 2) * d), 0);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          if (addr[0]) begin
            issue_cmd(CMD_READ, 8'($urandom), 1'(i < n - 1), SDA_RANDOM, 0, 0);
          end else begin
            issue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 0, 0);
            issue_cmd(CMD_WAIT, 8'($urandom), 1'($urandom), SDA_ACK_AT,
                      $urandom_range(0, (lim + 2) * d), 0);
          end
        end
        if ($urandom_range(0, 4) != 0)
          issue_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 0, 0);
      end else if (kind == 7) begin
        issue_cmd(($urandom_range(0, 1) != 0) ? CMD_ACK : CMD_NACK, 8'($urandom),
                  1'($urandom), SDA_RANDOM, 0, 0);
      end else if (kind == 8) begin
        issue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                  sda_mode_e'($urandom_range(0, 2)), $urandom_range(0, 12), 0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it.command_valid  = 1'($urandom);
          it.command        = it.command_valid ? CMD_UNUSED : 3'($urandom);
          it.tx_byte        = 8'($urandom);
          it.ack_after_read = 1'($urandom);
          it.sda_sample     = 1'($urandom);
          send_tick(it);
        end
      end
    end
  endtask

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (line_expected.size() == 0) begin
        note_failure($sformatf("unexpected result %s", show_line(out_if.data)));
      end else begin
        want = line_expected.pop_front();
        if (want.scl_level !== out_if.data.scl_level ||
            want.sda_level !== out_if.data.sda_level ||
            want.busy_res !== out_if.data.busy_res ||
            want.done_res !== out_if.data.done_res ||
            want.rx_byte !== out_if.data.rx_byte ||
            want.ack_failed !== out_if.data.ack_failed)
          note_failure($sformatf("result %0d expected %s got %s", results_seen,
                                 show_line(want), show_line(out_if.data)));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = 1'b0;
    cfg_wdata_i = 16'd0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_each_command();
    test_ack_limits();
    test_delay_extremes();
    test_output_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (line_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d ticks (%0d inside sequences), %0d commands started, %0d register writes",
             ticks_sent, active_ticks, cmds_started, cfg_writes);
    $display("checked %0d results with %0d mismatches; delays 0 to 40, ack limits 0 to 255,",
             results_seen, mismatches);
    $display("one %0d-cycle hold-off on the result side", hold_len);
    if (mismatches == 0 && line_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: i2c_master_bit_sequencer.f
rtl/core/i2cms_pkg.sv
rtl/core/i2cms_if.sv
rtl/core/i2cms_step.sv
rtl/core/i2c_master_bit_sequencer.sv
rtl/core/i2cms_checker.sv
verif/i2c_master_bit_sequencer_tb.sv
